### rtl/core/cfs_pkg.sv
package cfs_pkg;

    localparam logic [7:0] BOM_B0 = 8'hEF;
    localparam logic [7:0] BOM_B1 = 8'hBB;
    localparam logic [7:0] BOM_B2 = 8'hBF;

    localparam logic [1:0] FMT_JSON = 2'd0;
    localparam logic [1:0] FMT_YAML = 2'd1;
    localparam logic [1:0] FMT_TOML = 2'd2;
    localparam logic [1:0] FMT_INI  = 2'd3;

    localparam logic [6:0] CONF_NONE      = 7'd0;
    localparam logic [6:0] CONF_DEFAULT   = 7'd30;
    localparam logic [6:0] CONF_HINT_JSON = 7'((30 + 80) / 2);
    localparam logic [6:0] CONF_HINT      = 7'd60;
    localparam logic [6:0] CONF_JSON      = 7'd90;
    localparam logic [6:0] CONF_YAML      = 7'd95;
    localparam logic [6:0] CONF_TOML      = 7'd85;
    localparam logic [6:0] CONF_INI       = 7'd85;

    localparam logic REG_HINT_PRESENT = 1'b0;
    localparam logic REG_HINT_FORMAT  = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       no_data;
    } t_req;

    typedef struct packed {
        logic [1:0] format_code;
        logic [6:0] confidence;
    } t_rsp;

    // per-buffer verdict from the recognizers
    typedef struct packed {
        logic empty_buf;
        logic json_hit;
        logic yaml_hit;
        logic toml_hit;
        logic ini_hit;
    } t_verdict;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09);
    endfunction

    function automatic logic is_space4(input logic [7:0] c);
        return is_blank(c) || (c == 8'h0A) || (c == 8'h0D);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_letter(c) || ((c >= 8'h30) && (c <= 8'h39));
    endfunction

endpackage

### rtl/core/config_format_sniffer_top.sv
// Channel   Direction  Handshake         Payload
// request   in         push / full       i_req (data_byte, last_byte, no_data)
// result    out        pop / empty       o_rsp (format_code, confidence)
// config    in         i_cfg_we          i_cfg_idx, i_cfg_wdata
//
// One request per cycle while full is low; recognizers advance one byte per cycle.
// A last_byte result is registered in the queue, then in the output register.
// Verdict queue holds 2 buffers; full rises when it and the output register fill.
// Synchronous active-low reset clears the recognizers, queue, output and hint.
module config_format_sniffer_top
    import cfs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  t_req       i_req,
    output logic       empty,
    input  logic       pop,
    output t_rsp       o_rsp,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [1:0] i_cfg_wdata
);

    logic     take;
    logic     v_push;
    t_verdict v_in;
    t_verdict v_out;
    logic     q_full;
    logic     q_empty;
    logic     q_pop;

    assign full = q_full;
    assign take = push && !q_full;

    cfs_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_req     (i_req),
        .o_push    (v_push),
        .o_verdict (v_in)
    );

    cfs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (v_push),
        .i_data  (v_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (v_out)
    );

    cfs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_empty   (q_empty),
        .i_verdict   (v_out),
        .o_q_pop     (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_rsp       (o_rsp)
    );

endmodule

### rtl/core/cfs_front.sv
module cfs_front
    import cfs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_take,
    input  t_req     i_req,
    output logic     o_push,
    output t_verdict o_verdict
);

    typedef enum logic [2:0] {
        J_BOM0, J_BOM1, J_BOM2, J_WS, J_BRK, J_YES, J_NO
    } t_json;

    typedef enum logic [2:0] {
        Y_WS, Y_KEY, Y_SP, Y_COL, Y_YES, Y_NO
    } t_yaml;

    typedef enum logic [3:0] {
        T_WS, T_KEY, T_KSP, T_SEC, T_ANL, T_EQ1, T_EQ2, T_YES, T_NO
    } t_toml;

    typedef enum logic [1:0] {
        I_WS, I_YES, I_NO
    } t_ini;

    logic [1:0] r_cnt, n_cnt;
    t_json      r_json, n_json;
    t_yaml      r_yaml, n_yaml;
    t_toml      r_toml, n_toml;
    t_ini       r_ini, n_ini;
    logic [7:0] r_prev, n_prev;
    logic       r_dash, n_dash;

    logic [7:0] c;
    logic       ykey, tkey, feed, long3;

    function automatic t_json json_lead(input logic [7:0] b);
        if (is_space4(b)) return J_WS;
        if (b == 8'h7B) return J_YES;
        if (b == 8'h5B) return J_BRK;
        return J_NO;
    endfunction

    assign c    = i_req.data_byte;
    assign ykey = is_alnum(c) || (c == 8'h5F) || (c == 8'h2D);
    assign tkey = is_alnum(c) || (c == 8'h5F) || (c == 8'h2E);
    assign feed = i_take && !i_req.no_data;

    always_comb begin
        n_cnt  = r_cnt;
        n_json = r_json;
        n_yaml = r_yaml;
        n_toml = r_toml;
        n_ini  = r_ini;
        n_prev = r_prev;
        n_dash = r_dash;
        if (feed) begin
            if (r_cnt != 2'd3 && c != 8'h2D) n_dash = 1'b0;

            unique case (r_json)
                J_BOM0:  n_json = (c == BOM_B0) ? J_BOM1 : json_lead(c);
                J_BOM1:  n_json = (c == BOM_B1) ? J_BOM2 : J_NO;
                J_BOM2:  n_json = (c == BOM_B2) ? J_WS : J_NO;
                J_WS:    n_json = json_lead(c);
                J_BRK: begin
                    if (!is_blank(c)) n_json = is_letter(c) ? J_NO : J_YES;
                end
                default: n_json = r_json;
            endcase

            unique case (r_yaml)
                Y_WS: begin
                    if (!is_space4(c))
                        n_yaml = ykey ? Y_KEY : (c == 8'h3A) ? Y_COL : Y_NO;
                end
                Y_KEY: begin
                    if (!ykey)
                        n_yaml = is_blank(c) ? Y_SP : (c == 8'h3A) ? Y_COL : Y_NO;
                end
                Y_SP: begin
                    if (!is_blank(c)) n_yaml = (c == 8'h3A) ? Y_COL : Y_NO;
                end
                Y_COL:   n_yaml = is_space4(c) ? Y_YES : Y_NO;
                default: n_yaml = r_yaml;
            endcase

            unique case (r_toml)
                T_WS: begin
                    if (!is_space4(c))
                        n_toml = (c == 8'h5B) ? T_SEC : tkey ? T_KEY :
                                 (c == 8'h3D) ? T_YES : T_NO;
                end
                T_KEY: begin
                    if (!tkey)
                        n_toml = is_blank(c) ? T_KSP : (c == 8'h3D) ? T_YES : T_NO;
                end
                T_KSP: begin
                    if (!is_blank(c)) n_toml = (c == 8'h3D) ? T_YES : T_NO;
                end
                T_SEC: begin
                    if (c == 8'h0A) n_toml = T_ANL;
                end
                T_ANL: begin
                    if (c == 8'h3D) n_toml = (r_prev == 8'h20) ? T_EQ1 : T_NO;
                end
                T_EQ1:   n_toml = (c == 8'h20) ? T_EQ2 : T_NO;
                T_EQ2:   n_toml = T_YES;
                default: n_toml = r_toml;
            endcase
            n_prev = c;

            if (r_ini == I_WS && !is_space4(c))
                n_ini = (c == 8'h5B || c == 8'h3B) ? I_YES : I_NO;

            if (r_cnt != 2'd3) n_cnt = r_cnt + 2'd1;
        end
    end

    assign long3 = (n_cnt == 2'd3);

    always_comb begin
        o_push              = i_take && i_req.last_byte;
        o_verdict.empty_buf = (n_cnt == 2'd0);
        o_verdict.json_hit  = (n_json == J_YES) || (n_json == J_BRK);
        o_verdict.yaml_hit  = (long3 && n_dash) || (n_yaml == Y_YES) || (n_yaml == Y_COL);
        o_verdict.toml_hit  = long3 && (n_toml == T_YES);
        o_verdict.ini_hit   = long3 && (n_ini == I_YES);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_req.last_byte)) begin
            r_cnt  <= 2'd0;
            r_json <= J_BOM0;
            r_yaml <= Y_WS;
            r_toml <= T_WS;
            r_ini  <= I_WS;
            r_prev <= 8'd0;
            r_dash <= 1'b1;
        end else begin
            r_cnt  <= n_cnt;
            r_json <= n_json;
            r_yaml <= n_yaml;
            r_toml <= n_toml;
            r_ini  <= n_ini;
            r_prev <= n_prev;
            r_dash <= n_dash;
        end
    end

endmodule

### rtl/core/cfs_queue.sv
module cfs_queue
    import cfs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_verdict i_data,
    output logic     o_full,
    input  logic     i_pop,
    output logic     o_empty,
    output t_verdict o_data
);

    t_verdict   r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push, do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) r_wr_ptr <= ~r_wr_ptr;
            if (do_pop) r_rd_ptr <= ~r_rd_ptr;
            r_count <= r_count + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

### rtl/core/cfs_back.sv
module cfs_back
    import cfs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [1:0] i_cfg_wdata,
    input  logic       i_q_empty,
    input  t_verdict   i_verdict,
    output logic       o_q_pop,
    input  logic       i_pop,
    output logic       o_empty,
    output t_rsp       o_rsp
);

    logic       r_hint_present;
    logic [1:0] r_hint_format;
    logic       r_out_valid;
    t_rsp       r_out;
    t_rsp       n_out;

    always_comb begin
        n_out.format_code = FMT_JSON;
        n_out.confidence  = CONF_DEFAULT;
        if (i_verdict.empty_buf) begin
            if (r_hint_present) begin
                n_out.format_code = r_hint_format;
                n_out.confidence  = (r_hint_format != FMT_JSON) ? CONF_HINT : CONF_DEFAULT;
            end else begin
                n_out.confidence = CONF_NONE;
            end
        end else begin
            priority if (i_verdict.json_hit) begin
                n_out.confidence = CONF_JSON;
            end else if (i_verdict.yaml_hit) begin
                n_out.format_code = FMT_YAML;
                n_out.confidence  = CONF_YAML;
            end else if (i_verdict.toml_hit) begin
                n_out.format_code = FMT_TOML;
                n_out.confidence  = CONF_TOML;
            end else if (i_verdict.ini_hit) begin
                n_out.format_code = FMT_INI;
                n_out.confidence  = CONF_INI;
            end else if (r_hint_present) begin
                if (r_hint_format != FMT_JSON) begin
                    n_out.format_code = r_hint_format;
                    n_out.confidence  = CONF_HINT;
                end else begin
                    n_out.confidence = CONF_HINT_JSON;
                end
            end else begin
                n_out.confidence = CONF_DEFAULT;
            end
        end
    end

    assign o_q_pop = !i_q_empty && (!r_out_valid || i_pop);
    assign o_empty = !r_out_valid;
    assign o_rsp   = r_out;

    always_ff @(posedge i_clk) begin
        if (o_q_pop) r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid    <= 1'b0;
            r_hint_present <= 1'b0;
            r_hint_format  <= FMT_JSON;
        end else begin
            if (o_q_pop) r_out_valid <= 1'b1;
            else if (i_pop) r_out_valid <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_HINT_PRESENT: r_hint_present <= i_cfg_wdata[0];
                    REG_HINT_FORMAT:  r_hint_format  <= i_cfg_wdata;
                    default:          r_hint_format  <= r_hint_format;
                endcase
            end
        end
    end

endmodule

### verif/config_format_sniffer_top_test.sv
`timescale 1ns / 1ps

module config_format_sniffer_top_test;
    import cfs_pkg::*;

    localparam int STUCK_LIMIT = 5000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 250;
    localparam int HOLD_OFF    = 80;

    localparam logic [7:0] CH_SP     = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_A_LO   = 8'h61;
    localparam logic [7:0] CH_A_UP   = 8'h41;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    typedef enum logic [2:0] {JS_BOM0, JS_BOM1, JS_BOM2, JS_WS, JS_BRK, JS_YES, JS_NO} json_st_e;
    typedef enum logic [2:0] {YM_WS, YM_KEY, YM_SP, YM_COL, YM_YES, YM_NO} yaml_st_e;
    typedef enum logic [3:0] {
        TM_WS, TM_KEY, TM_KSP, TM_SEC, TM_ANL, TM_EQ1, TM_EQ2, TM_YES, TM_NO
    } toml_st_e;
    typedef enum logic [1:0] {IN_WS, IN_YES, IN_NO} ini_st_e;

    class format_verdict_tracker;
        logic       hint_on;
        logic [1:0] hint_fmt;
        logic [1:0] seen;
        json_st_e   js;
        yaml_st_e   ys;
        toml_st_e   ts;
        ini_st_e    is;
        logic [7:0] prev_char;
        bit         dash_run;
        t_rsp       awaited[$];
        int         errors;

        function new();
            hint_on  = 1'b0;
            hint_fmt = FMT_JSON;
            errors   = 0;
            clear();
        endfunction

        function void clear();
            seen      = 2'd0;
            js        = JS_BOM0;
            ys        = YM_WS;
            ts        = TM_WS;
            is        = IN_WS;
            prev_char = 8'h00;
            dash_run  = 1'b1;
        endfunction

        function bit blank(logic [7:0] c);
            return c == CH_SP || c == CH_TAB;
        endfunction

        function bit wspace(logic [7:0] c);
            return blank(c) || c == CH_LF || c == CH_CR;
        endfunction

        function bit alpha(logic [7:0] c);
            return (c >= CH_A_LO && c <= 8'h7A) || (c >= CH_A_UP && c <= 8'h5A);
        endfunction

        function bit alnum_c(logic [7:0] c);
            return alpha(c) || (c >= CH_ZERO && c <= 8'h39);
        endfunction

        function json_st_e json_start(logic [7:0] c);
            if (wspace(c)) return JS_WS;
            if (c == CH_LBRACE) return JS_YES;
            if (c == CH_LBRACK) return JS_BRK;
            return JS_NO;
        endfunction

        function void advance(logic [7:0] c);
            bit ykey;
            bit tkey;
            ykey = alnum_c(c) || c == CH_USCORE || c == CH_DASH;
            tkey = alnum_c(c) || c == CH_USCORE || c == CH_DOT;
            if (seen != 2'd3 && c != CH_DASH) dash_run = 1'b0;

            case (js)
                JS_BOM0: js = (c == BOM_B0) ? JS_BOM1 : json_start(c);
                JS_BOM1: js = (c == BOM_B1) ? JS_BOM2 : JS_NO;
                JS_BOM2: js = (c == BOM_B2) ? JS_WS : JS_NO;
                JS_WS:   js = json_start(c);
                JS_BRK: begin
                    if (!blank(c)) js = alpha(c) ? JS_NO : JS_YES;
                end
                default: begin
                end
            endcase

            case (ys)
                YM_WS: begin
                    if (!wspace(c)) ys = ykey ? YM_KEY : (c == CH_COLON) ? YM_COL : YM_NO;
                end
                YM_KEY: begin
                    if (!ykey) ys = blank(c) ? YM_SP : (c == CH_COLON) ? YM_COL : YM_NO;
                end
                YM_SP: begin
                    if (!blank(c)) ys = (c == CH_COLON) ? YM_COL : YM_NO;
                end
                YM_COL: ys = wspace(c) ? YM_YES : YM_NO;
                default: begin
                end
            endcase

            case (ts)
                TM_WS: begin
                    if (!wspace(c)) begin
                        ts = (c == CH_LBRACK) ? TM_SEC : tkey ? TM_KEY :
                             (c == CH_EQ) ? TM_YES : TM_NO;
                    end
                end
                TM_KEY: begin
                    if (!tkey) ts = blank(c) ? TM_KSP : (c == CH_EQ) ? TM_YES : TM_NO;
                end
                TM_KSP: begin
                    if (!blank(c)) ts = (c == CH_EQ) ? TM_YES : TM_NO;
                end
                TM_SEC: begin
                    if (c == CH_LF) ts = TM_ANL;
                end
                TM_ANL: begin
                    if (c == CH_EQ) ts = (prev_char == CH_SP) ? TM_EQ1 : TM_NO;
                end
                TM_EQ1: ts = (c == CH_SP) ? TM_EQ2 : TM_NO;
                TM_EQ2: ts = TM_YES;
                default: begin
                end
            endcase
            prev_char = c;

            if (is == IN_WS && !wspace(c)) is = (c == CH_LBRACK || c == CH_SEMI) ? IN_YES : IN_NO;

            if (seen != 2'd3) seen = seen + 2'd1;
        endfunction

        function t_rsp verdict();
            t_rsp v;
            bit   long3;
            v.format_code = FMT_JSON;
            v.confidence  = CONF_DEFAULT;
            long3 = seen == 2'd3;
            if (seen == 2'd0) begin
                if (hint_on) begin
                    v.format_code = hint_fmt;
                    v.confidence  = (hint_fmt != FMT_JSON) ? CONF_HINT : CONF_DEFAULT;
                end else begin
                    v.confidence = CONF_NONE;
                end
            end else if (js == JS_YES || js == JS_BRK) begin
                v.confidence = CONF_JSON;
            end else if ((long3 && dash_run) || ys == YM_YES || ys == YM_COL) begin
                v.format_code = FMT_YAML;
                v.confidence  = CONF_YAML;
            end else if (long3 && ts == TM_YES) begin
                v.format_code = FMT_TOML;
                v.confidence  = CONF_TOML;
            end else if (long3 && is == IN_YES) begin
                v.format_code = FMT_INI;
                v.confidence  = CONF_INI;
            end else if (hint_on) begin
                if (hint_fmt != FMT_JSON) begin
                    v.format_code = hint_fmt;
                    v.confidence  = CONF_HINT;
                end else begin
                    v.confidence = CONF_HINT_JSON;
                end
            end
            return v;
        endfunction

        function void set_reg(logic idx, logic [1:0] data);
            if (idx == REG_HINT_PRESENT) hint_on = data[0];
            else hint_fmt = data;
        endfunction

        function void note_req(t_req r);
            if (!r.no_data) advance(r.data_byte);
            if (r.last_byte) begin
                awaited.push_back(verdict());
                clear();
            end
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $time, msg);
            errors++;
        endtask

        task check_rsp(t_rsp got);
            t_rsp want;
            if (awaited.size() == 0) begin
                report($sformatf("result fmt %0d conf %0d with no buffer pending",
                                 got.format_code, got.confidence));
                return;
            end
            want = awaited.pop_front();
            if (got.format_code !== want.format_code)
                report($sformatf("format %0d, expected %0d", got.format_code, want.format_code));
            if (got.confidence !== want.confidence)
                report($sformatf("confidence %0d, expected %0d", got.confidence, want.confidence));
        endtask
    endclass

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       push        = 1'b0;
    logic       pop         = 1'b0;
    t_req       i_req       = '0;
    logic       i_cfg_we    = 1'b0;
    logic       i_cfg_idx   = 1'b0;
    logic [1:0] i_cfg_wdata = 2'b00;
    logic       full;
    logic       empty;
    t_rsp       o_rsp;

    format_verdict_tracker tracker = new();
    logic [7:0] stream[$];
    bit         quiet       = 1'b0;
    int         hold_cycles = 0;
    int         tx_gap_odds = 0;
    int         items_sent  = 0;
    int         stuck       = 0;

    bit         plan_on[PHASES]  = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
    logic [1:0] plan_fmt[PHASES] = '{FMT_INI, FMT_JSON, FMT_TOML, FMT_YAML,
                                     FMT_TOML, FMT_JSON, FMT_INI, FMT_YAML};

    config_format_sniffer_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_req       (i_req),
        .empty       (empty),
        .pop         (pop),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int pick_odds();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 8;
            default: return 3;
        endcase
    endfunction

    function automatic t_req mk_req(logic [7:0] b, logic last, logic nd);
        t_req r;
        r.data_byte = b;
        r.last_byte = last;
        r.no_data   = nd;
        return r;
    endfunction

    function automatic logic [7:0] pick_ws();
        case ($urandom_range(0, 3))
            0: return CH_SP;
            1: return CH_TAB;
            2: return CH_LF;
            default: return CH_CR;
        endcase
    endfunction

    function automatic logic [7:0] pick_key(bit toml_set);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return 8'(CH_A_LO + $urandom_range(0, 25));
            6: return 8'(CH_A_UP + $urandom_range(0, 25));
            7: return 8'(CH_ZERO + $urandom_range(0, 9));
            8: return CH_USCORE;
            default: return toml_set ? CH_DOT : CH_DASH;
        endcase
    endfunction

    function automatic logic [7:0] pick_text();
        case ($urandom_range(0, 9))
            0, 1: return 8'($urandom);
            2: return pick_ws();
            3: return CH_COLON;
            4: return CH_EQ;
            5: return CH_LBRACK;
            6: return CH_LBRACE;
            7: return ($urandom_range(0, 1) == 1) ? CH_SEMI : CH_QUOTE;
            default: return pick_key(1'($urandom_range(0, 1)));
        endcase
    endfunction

    function automatic void add_ws(int most);
        repeat ($urandom_range(0, most)) stream.push_back(pick_ws());
    endfunction

    function automatic void add_blanks(int most);
        repeat ($urandom_range(0, most)) stream.push_back($urandom_range(0, 1) ? CH_SP : CH_TAB);
    endfunction

    function automatic void add_key(int most, bit toml_set);
        repeat ($urandom_range(1, most)) stream.push_back(pick_key(toml_set));
    endfunction

    function automatic void add_text(int most);
        repeat ($urandom_range(0, most)) stream.push_back(pick_text());
    endfunction

    function automatic void add_str(string s);
        for (int k = 0; k < s.len(); k++) stream.push_back(s[k]);
    endfunction

    task automatic pause_tx(int n);
        @(negedge i_clk);
        push  <= 1'b0;
        i_req <= mk_req(8'($urandom), 1'($urandom), 1'($urandom));
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic offer(t_req r);
        if (!quiet && tx_gap_odds != 0 && $urandom_range(1, tx_gap_odds) == 1)
            pause_tx($urandom_range(1, 10));
        @(negedge i_clk);
        push  <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (full);
        tracker.note_req(r);
    endtask

    // split_end closes the buffer with a separate no-byte request
    task automatic send_buffer(bit split_end, bit sprinkle);
        int n;
        n = stream.size();
        if (n == 0) begin
            offer(mk_req(8'($urandom), 1'b1, 1'b1));
            items_sent++;
        end else begin
            foreach (stream[k]) begin
                if (sprinkle && $urandom_range(0, 15) == 0)
                    offer(mk_req(8'($urandom), 1'b0, 1'b1));
                offer(mk_req(stream[k], (k == n - 1) && !split_end, 1'b0));
                items_sent++;
            end
            if (split_end) begin
                offer(mk_req(8'($urandom), 1'b1, 1'b1));
                items_sent++;
            end
        end
        stream.delete();
    endtask

    task automatic build_buffer();
        int n;
        case ($urandom_range(0, 7))
            0: begin
                if ($urandom_range(0, 2) == 0) begin
                    stream.push_back(BOM_B0);
                    stream.push_back(BOM_B1);
                    stream.push_back(BOM_B2);
                end
                add_ws(3);
                if ($urandom_range(0, 1) == 1) begin
                    stream.push_back(CH_LBRACE);
                end else begin
                    stream.push_back(CH_LBRACK);
                    add_blanks(2);
                end
                add_text(4);
            end
            1: begin
                repeat (3) stream.push_back(CH_DASH);
                add_text(4);
            end
            2: begin
                add_ws(2);
                add_key(5, 1'b0);
                add_blanks(2);
                stream.push_back(CH_COLON);
                add_text(4);
            end
            3: begin
                add_ws(2);
                add_key(5, 1'b1);
                add_blanks(2);
                stream.push_back(CH_EQ);
                add_text(3);
            end
            4: begin
                add_ws(1);
                stream.push_back(CH_LBRACK);
                add_key(4, 1'b1);
                if ($urandom_range(0, 3) != 0) stream.push_back(CH_RBRACK);
                stream.push_back(CH_LF);
                add_key(3, 1'b1);
                if ($urandom_range(0, 3) != 0) stream.push_back(CH_SP);
                stream.push_back(CH_EQ);
                if ($urandom_range(0, 3) != 0) stream.push_back(CH_SP);
                add_text(2);
            end
            5: begin
                add_ws(2);
                stream.push_back($urandom_range(0, 1) ? CH_LBRACK : CH_SEMI);
                add_text(5);
            end
            default: begin
                repeat ($urandom_range(0, 8)) stream.push_back(8'($urandom));
            end
        endcase
        // broken variants: one byte corrupted or the tail cut off
        if (stream.size() != 0 && $urandom_range(0, 4) == 0) begin
            if ($urandom_range(0, 1) == 1) begin
                stream[$urandom_range(0, stream.size() - 1)] = 8'($urandom);
            end else begin
                n = $urandom_range(0, stream.size() - 1);
                while (stream.size() > n) void'(stream.pop_back());
            end
        end
    endtask

    task automatic settle();
        @(negedge i_clk);
        push <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        tracker.set_reg(idx, data);
    endtask

    task automatic write_hints(logic on, logic [1:0] fmt);
        settle();
        write_reg(REG_HINT_PRESENT, {1'($urandom), on});
        write_reg(REG_HINT_FORMAT, fmt);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) tracker.check_rsp(o_rsp);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) stuck <= 0;
        else stuck <= stuck + 1;
        if (stuck >= STUCK_LIMIT) begin
            $display("config_format_sniffer_top_test: FAIL");
            $finish;
        end
    end

    initial begin : rx
        int stall_left;
        int mode_left;
        int gap_odds;
        stall_left = 0;
        mode_left  = 0;
        gap_odds   = 0;
        forever begin
            @(negedge i_clk);
            if (mode_left == 0) begin
                mode_left = 100;
                gap_odds  = pick_odds();
            end
            mode_left--;
            if (hold_cycles > 0) begin
                hold_cycles--;
                pop <= 1'b0;
            end else if (quiet) begin
                pop <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                pop <= 1'b0;
            end else if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
                stall_left = $urandom_range(0, 9);
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    initial begin : tx
        int target;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // registers at reset value: no hint
        send_buffer(1'b0, 1'b0);
        add_str("{");
        send_buffer(1'b0, 1'b0);
        stream.push_back(BOM_B0);
        stream.push_back(BOM_B1);
        stream.push_back(BOM_B2);
        add_str(" [1");
        send_buffer(1'b0, 1'b0);
        add_str("---");
        send_buffer(1'b0, 1'b0);
        add_str("a:");
        send_buffer(1'b0, 1'b0);
        add_str("k=1");
        send_buffer(1'b0, 1'b0);
        add_str("[a\n = 1");
        send_buffer(1'b0, 1'b0);
        // ignored no-byte request mid-buffer, then end without a byte
        offer(mk_req(CH_SEMI, 1'b0, 1'b0));
        offer(mk_req(8'h00, 1'b0, 1'b1));
        offer(mk_req(CH_A_LO, 1'b0, 1'b0));
        offer(mk_req(8'hFF, 1'b0, 1'b0));
        offer(mk_req(8'hFF, 1'b1, 1'b1));

        write_hints(1'b1, FMT_TOML);
        send_buffer(1'b0, 1'b0);
        stream.push_back(8'h00);
        add_str("a");
        send_buffer(1'b0, 1'b0);

        write_hints(1'b1, FMT_JSON);
        send_buffer(1'b0, 1'b0);
        add_str("zz");
        send_buffer(1'b1, 1'b0);

        for (int ph = 0; ph < PHASES; ph++) begin
            write_hints(plan_on[ph], (ph >= 6) ? 2'($urandom) : plan_fmt[ph]);
            tx_gap_odds = pick_odds();
            if (ph == 1) begin
                tx_gap_odds = 0;
                hold_cycles = HOLD_OFF;
            end
            if (ph == PHASES - 1) quiet = 1'b1;
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                if ($urandom_range(0, 7) == 0) tx_gap_odds = pick_odds();
                build_buffer();
                send_buffer($urandom_range(0, 3) == 0, 1'b1);
            end
        end

        @(negedge i_clk);
        push <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (tracker.outstanding() != 0)
            tracker.report($sformatf("%0d results never came", tracker.outstanding()));
        if (tracker.errors == 0) begin
            $display("config_format_sniffer_top_test: PASS");
        end else begin
            $display("config_format_sniffer_top_test: FAIL");
        end
        $finish;
    end

endmodule
